/* rtl/sdpe_pkg.sv */
`default_nettype none
package sdpe_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned TimeW = 32;
  localparam int unsigned PosW  = 32;
  localparam int unsigned ConfW = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned RegW  = 16;
  localparam int unsigned CfgIdxW = 2;
  // Widths of the time differences, the delta times horizon product and the divider.
  localparam int unsigned DiffW = 33;
  localparam int unsigned ProdW = 50;
  localparam int unsigned QuotW = 50;
  localparam int unsigned DivCntW = 6;

  localparam logic [CmdW-1:0] CMD_TICK   = 3'd0;
  localparam logic [CmdW-1:0] CMD_CAMERA = 3'd1;
  localparam logic [CmdW-1:0] CMD_LIDAR  = 3'd2;
  localparam logic [CmdW-1:0] CMD_POSE   = 3'd3;
  localparam logic [CmdW-1:0] CMD_MODE   = 3'd4;

  localparam logic [KindW-1:0] KIND_DROPOUT = 2'd0;
  localparam logic [KindW-1:0] KIND_SKEW    = 2'd1;
  localparam logic [KindW-1:0] KIND_IDLE    = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_INT  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WINDOW   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_IDLE_PER = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] stamp_ms;
    logic [PosW-1:0]  pose_x;
    logic [PosW-1:0]  pose_y;
    logic [PosW-1:0]  pose_z;
    logic [ConfW-1:0] pose_confidence;
    logic             idle_on;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [TimeW-1:0]  out_stamp_ms;
    logic [PosW-1:0]   out_x;
    logic [PosW-1:0]   out_y;
    logic [PosW-1:0]   out_z;
    logic [ConfW-1:0]  out_confidence;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;      // capture the input item
    logic       eval;      // register the tick decision or apply event updates
    logic       axis_start; // start one axis division
    logic [1:0] axis;      // axis in work
    logic       axis_store; // store finished axis
    logic       commit;    // register result and tick state updates
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic emit;        // tick produces a result
    logic extrap;      // result needs the division pass
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/sdpe_stream_if.sv */
`default_nettype none
interface sdpe_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/sdpe_divider.sv */
`default_nettype none
module sdpe_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [sdpe_pkg::ProdW-1:0]   dividend,
  input  wire logic [sdpe_pkg::DiffW-2:0]   divisor,
  output logic      [sdpe_pkg::QuotW-1:0]   quotient,
  output logic                              done
);
  import sdpe_pkg::*;

  logic [ProdW-1:0]   num;
  logic [DiffW-1:0]   rem;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic [DiffW:0]     trial;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, num[ProdW-1]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= dividend;
        rem  <= '0;
        cnt  <= DivCntW'(ProdW);
      end else if (busy) begin
        if (!trial[DiffW]) begin
          rem <= trial[DiffW-1:0];
          num <= {num[ProdW-2:0], 1'b1};
        end else begin
          rem <= {rem[DiffW-2:0], num[ProdW-1]};
          num <= {num[ProdW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = num;
endmodule
`default_nettype wire

/* rtl/sdpe_datapath.sv */
`default_nettype none
module sdpe_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [sdpe_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [sdpe_pkg::RegW-1:0]    cfg_data,
  input  wire sdpe_pkg::in_item_t    in_item,
  input  wire sdpe_pkg::dp_cmd_t     cmd,
  output sdpe_pkg::dp_sts_t          sts,
  output sdpe_pkg::out_item_t        out_item
);
  import sdpe_pkg::*;

  logic [RegW-1:0] timeout_ms, min_int_ms, window_ms, idle_per_ms;
  logic [TimeW-1:0] cam_stamp, cam_arr, lid_stamp, lid_arr;
  logic cam_seen, lid_seen;
  logic [TimeW-1:0] ptime0, ptime1;
  logic signed [PosW-1:0] lat [3];
  logic signed [PosW-1:0] prv [3];
  logic [ConfW-1:0] pconf;
  logic [1:0] pcount;
  logic [TimeW-1:0] last_ext, last_idle;
  logic ext_sent, idle_mode, idle_sent;
  in_item_t item;

  // Registered decision.
  logic is_tick, emit_r, extrap_r, kind_one, idle_hit;
  logic [DiffW-2:0] dt_r;
  logic [RegW-1:0] h_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms  <= RegW'(150);
      min_int_ms  <= RegW'(40);
      window_ms   <= RegW'(300);
      idle_per_ms <= RegW'(200);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:  timeout_ms  <= cfg_data;
        REG_MIN_INT:  min_int_ms  <= cfg_data;
        REG_WINDOW:   window_ms   <= cfg_data;
        REG_IDLE_PER: idle_per_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Signed 33-bit time differences.
  function automatic logic signed [DiffW-1:0] tdiff(input logic [TimeW-1:0] a,
                                                      input logic [TimeW-1:0] b);
    tdiff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  logic signed [DiffW-1:0] gc, gl, sk, ske, el_ext, el_idle, dt, hraw;
  logic signed [DiffW-1:0] tt;
  logic one_c, skew_c, soon_c, idle_ok, ext_c;
  logic [RegW-1:0] h_c;

  always_comb begin
    tt      = $signed({{(DiffW-RegW){1'b0}}, timeout_ms});
    gc      = tdiff(item.now_ms, cam_arr);
    gl      = tdiff(item.now_ms, lid_arr);
    sk      = tdiff(cam_stamp, lid_stamp);
    ske     = sk[DiffW-1] ? -sk : sk;
    one_c   = (gc > tt && gl <= tt) || (gl > tt && gc <= tt);
    skew_c  = ske > tt;
    el_ext  = tdiff(item.now_ms, last_ext);
    soon_c  = ext_sent && (el_ext < $signed({{(DiffW-RegW){1'b0}}, min_int_ms}));
    el_idle = tdiff(item.now_ms, last_idle);
    idle_ok = !(idle_sent &&
                (el_idle < $signed({{(DiffW-RegW){1'b0}}, idle_per_ms})));
    dt      = tdiff(ptime0, ptime1);
    hraw    = tdiff(item.now_ms, ptime0);
    if (hraw[DiffW-1])
      h_c = '0;
    else if (hraw > $signed({{(DiffW-RegW){1'b0}}, window_ms}))
      h_c = window_ms;
    else
      h_c = hraw[RegW-1:0];
    ext_c = (pcount == 2'd2) && !dt[DiffW-1] && (dt != '0);
  end

  // Per-axis arithmetic: magnitude of delta times horizon, then division.
  logic signed [DiffW-1:0] dlt;
  logic [DiffW-2:0] dmag;
  logic [ProdW-1:0] prod;
  logic dneg;
  logic [QuotW-1:0] quot;
  logic qdone;
  logic start_d;
  logic signed [PosW-1:0] res [3];
  logic signed [QuotW+1:0] sum;

  always_comb begin
    dlt  = $signed({lat[cmd.axis][PosW-1], lat[cmd.axis]}) -
           $signed({prv[cmd.axis][PosW-1], prv[cmd.axis]});
    dneg = dlt[DiffW-1];
    dmag = dneg ? (DiffW-1)'(-dlt) : dlt[DiffW-2:0];
  end

  // Registered multiply ahead of the divider; the divider starts in the next
  // cycle, once the product of the current axis is in the register.
  always_ff @(posedge clk) begin
    prod <= ProdW'(dmag) * ProdW'(h_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_d <= 1'b0;
    end else begin
      start_d <= cmd.axis_start;
    end
  end

  sdpe_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_d),
    .dividend (prod),
    .divisor  (dt_r),
    .quotient (quot),
    .done     (qdone)
  );

  always_comb begin
    sum = $signed({{2{lat[cmd.axis][PosW-1]}}, {(QuotW-PosW){lat[cmd.axis][PosW-1]}},
                   lat[cmd.axis]}) +
          (dneg ? -$signed({2'b00, quot}) : $signed({2'b00, quot}));
  end

  // Event and tick state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_stamp <= '0; cam_arr <= '0; cam_seen <= 1'b0;
      lid_stamp <= '0; lid_arr <= '0; lid_seen <= 1'b0;
      ptime0 <= '0; ptime1 <= '0; pconf <= '0; pcount <= '0;
      for (int i = 0; i < 3; i++) begin
        lat[i] <= '0;
        prv[i] <= '0;
      end
      last_ext <= '0; last_idle <= '0;
      ext_sent <= 1'b0; idle_mode <= 1'b0; idle_sent <= 1'b0;
      is_tick <= 1'b0; emit_r <= 1'b0; extrap_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        item    <= in_item;
        is_tick <= (in_item.command == CMD_TICK);
      end
      if (cmd.eval && is_tick) begin
        idle_hit <= idle_mode;
        kind_one <= one_c;
        dt_r     <= dt[DiffW-2:0];
        h_r      <= h_c;
        extrap_r <= !idle_mode && ext_c;
        if (idle_mode)
          emit_r <= idle_ok;
        else
          emit_r <= cam_seen && lid_seen && (one_c || skew_c) && !soon_c &&
                    (pcount != 2'd0);
      end else if (cmd.eval) begin
        emit_r <= 1'b0;
        unique case (item.command)
          CMD_CAMERA: begin
            cam_stamp <= item.stamp_ms; cam_arr <= item.now_ms; cam_seen <= 1'b1;
          end
          CMD_LIDAR: begin
            lid_stamp <= item.stamp_ms; lid_arr <= item.now_ms; lid_seen <= 1'b1;
          end
          CMD_POSE: begin
            ptime1 <= ptime0;
            ptime0 <= item.now_ms;
            for (int i = 0; i < 3; i++) prv[i] <= lat[i];
            lat[0] <= item.pose_x;
            lat[1] <= item.pose_y;
            lat[2] <= item.pose_z;
            pconf <= item.pose_confidence;
            if (pcount != 2'd2) pcount <= pcount + 2'd1;
          end
          CMD_MODE: idle_mode <= item.idle_on;
          default: ;
        endcase
      end
      if (cmd.axis_store) begin
        if (sum > $signed({{(QuotW-PosW+3){1'b0}}, {(PosW-1){1'b1}}}))
          res[cmd.axis] <= {1'b0, {(PosW-1){1'b1}}};
        else if (sum < -$signed({{(QuotW-PosW+2){1'b0}}, 1'b1, {(PosW-1){1'b0}}}))
          res[cmd.axis] <= {1'b1, {(PosW-1){1'b0}}};
        else
          res[cmd.axis] <= sum[PosW-1:0];
      end
      if (cmd.commit) begin
        out_item.out_stamp_ms <= item.now_ms;
        if (idle_hit) begin
          out_item.kind <= KIND_IDLE;
          out_item.out_x <= '0; out_item.out_y <= '0; out_item.out_z <= '0;
          out_item.out_confidence <= '0;
          idle_sent <= 1'b1;
          last_idle <= item.now_ms;
        end else begin
          out_item.kind <= kind_one ? KIND_DROPOUT : KIND_SKEW;
          out_item.out_x <= extrap_r ? res[0] : lat[0];
          out_item.out_y <= extrap_r ? res[1] : lat[1];
          out_item.out_z <= extrap_r ? res[2] : lat[2];
          // Confidence times 4/5 by reciprocal multiply: floor(c*4*52429 >> 18).
          out_item.out_confidence <= ConfW'((({2'b00, pconf} * 36'd209716) >> 18));
          ext_sent <= 1'b1;
          last_ext <= item.now_ms;
        end
      end
    end
  end

  assign sts.is_tick  = is_tick;
  assign sts.emit     = emit_r;
  assign sts.extrap   = extrap_r;
  assign sts.div_done = qdone;
endmodule
`default_nettype wire

/* rtl/sdpe_controller.sv */
`default_nettype none
module sdpe_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire sdpe_pkg::dp_sts_t  sts,
  output sdpe_pkg::dp_cmd_t       cmd
);
  import sdpe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_DECIDE, S_MUL, S_DIV, S_COMMIT
  } state_t;

  state_t state;
  logic [1:0] axis;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.axis = axis;
    cmd.load = in_valid && in_ready;
    cmd.eval = (state == S_EVAL);
    cmd.axis_start = (state == S_MUL);
    cmd.axis_store = (state == S_DIV) && sts.div_done;
    cmd.commit = (state == S_COMMIT);
  end

  // Sequencer: event update or tick decision, three axis divisions when extrapolating, result when emitting.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:   if (in_valid && in_ready) state <= S_EVAL;
        S_EVAL:   state <= S_DECIDE;
        S_DECIDE: begin
          axis <= '0;
          if (!sts.emit) state <= S_IDLE;
          else if (sts.extrap) state <= S_MUL;
          else state <= S_COMMIT;
        end
        S_MUL:    state <= S_DIV;
        S_DIV: if (sts.div_done) begin
          if (axis == 2'd2) state <= S_COMMIT;
          else begin
            axis <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_COMMIT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/sensor_dropout_pose_extrapolator.sv */
`default_nettype none
// Sensor dropout pose extrapolator. Camera, lidar, pose and mode events pass
// through the idle (load), eval and decide states; a tick that yields nothing
// ends at decide, a plain pose or idle marker adds a commit step, and an
// extrapolated pose adds three axis passes before commit (each a registered
// multiply, then 50 steps of the single bit-serial divider). One item is in
// work at a time; the next is taken once the previous result has been taken.
module sensor_dropout_pose_extrapolator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [sdpe_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [sdpe_pkg::RegW-1:0]     cfg_data,
  sdpe_stream_if.sink                        in_ch,
  sdpe_stream_if.source                      out_ch
);
  import sdpe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  in_item_t in_item;
  out_item_t out_item;

  assign in_item = in_ch.payload;
  assign out_ch.payload = out_item;

  sdpe_controller u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  sdpe_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in_item), .cmd(cmd), .sts(sts), .out_item(out_item)
  );

  // A result is only raised from the commit step.
  a_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.commit)) else $error("result without commit");
  // No input is taken while a result waits.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
  // Division steps only follow an extrapolating decision.
  a_div: assert property (@(posedge clk) disable iff (rst)
    cmd.axis_start |-> sts.extrap) else $error("division without extrapolation");
endmodule
`default_nettype wire
